// ===== hdl/mer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Shared widths, datapath operations, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int AXIS_BITS  = 11;
    localparam int COORD_BITS = 13;
    localparam int CEN_BITS   = COORD_BITS - 1;
    localparam int DEC_BITS   = 48;
    localparam int SQ_BITS    = 2 * AXIS_BITS;
    localparam int MUL_A_W    = 2 * AXIS_BITS + 3;
    localparam int MUL_B_W    = 2 * AXIS_BITS + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int NUM_POINTS = 4;
    localparam int PT_BITS    = $clog2(NUM_POINTS);
    localparam logic [PT_BITS-1:0] PT_LAST = PT_BITS'(NUM_POINTS - 1);

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_SQ_B,
        OP_MUL_AB,
        OP_INIT_D,
        OP_T1,
        OP_T2,
        OP_TEST,
        OP_SQX,
        OP_BSQ,
        OP_SQY,
        OP_ASQ,
        OP_AB,
        OP_FIX,
        OP_U1,
        OP_U2,
        OP_U3,
        OP_V1,
        OP_V2,
        OP_V3,
        OP_EMIT
    } t_dp_op;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_B,
        ST_MUL_AB,
        ST_INIT_D,
        ST_T1,
        ST_T2,
        ST_TEST,
        ST_SQX,
        ST_BSQ,
        ST_SQY,
        ST_ASQ,
        ST_AB,
        ST_FIX,
        ST_U1,
        ST_U2,
        ST_U3,
        ST_V1,
        ST_V2,
        ST_V3,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_dp_op             op;
        logic [PT_BITS-1:0] pt;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;
        logic region_two;
        logic r1_switch;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== hdl/mer_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Holds the ellipse state, one shared registered multiplier, the decision
// accumulator and the output register for the plotted points.
// ----------------------------------------------------------------------------
module mer_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mer_pkg::t_dp_cmd                      i_cmd,
    input  logic signed [mer_pkg::CEN_BITS-1:0]   i_center_x,
    input  logic signed [mer_pkg::CEN_BITS-1:0]   i_center_y,
    input  logic        [mer_pkg::AXIS_BITS-1:0]  i_axis_a,
    input  logic        [mer_pkg::AXIS_BITS-1:0]  i_axis_b,
    input  logic                                  i_out_ready,
    output mer_pkg::t_dp_sts                      o_sts,
    output logic                                  o_out_valid,
    output logic signed [mer_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [mer_pkg::COORD_BITS-1:0] o_point_y,
    output logic                                  o_last_of_step,
    output logic                                  o_ellipse_done
);
    import mer_pkg::*;

    logic        [CEN_BITS-1:0]   r_cen_x;
    logic        [CEN_BITS-1:0]   r_cen_y;
    logic        [AXIS_BITS-1:0]  r_step_x, n_step_x;
    logic        [AXIS_BITS-1:0]  r_step_y, n_step_y;
    logic                         r_region_two, n_region_two;
    logic        [DEC_BITS-1:0]   r_dec, n_dec;
    logic        [SQ_BITS-1:0]    r_a_sq, n_a_sq;
    logic        [SQ_BITS-1:0]    r_b_sq, n_b_sq;
    logic signed [PROD_W-1:0]     r_prod, n_prod;
    logic signed [PROD_W-1:0]     r_prev, n_prev;
    logic                         r_neg, n_neg;
    logic                         r_out_valid, n_out_valid;
    logic        [COORD_BITS-1:0] r_point_x, n_point_x;
    logic        [COORD_BITS-1:0] r_point_y, n_point_y;
    logic                         r_last, r_done;

    logic signed [MUL_A_W-1:0]    mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     mul_p;
    logic        [DEC_BITS-1:0]   dec_prod;
    logic        [DEC_BITS-1:0]   dec_prod4;
    logic                         r1_switch;
    logic                         out_free;
    logic        [COORD_BITS-1:0] cx, cy, xe, ye;

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_LOAD: begin
                mul_a = MUL_A_W'(i_axis_a);
                mul_b = MUL_B_W'(i_axis_a);
            end
            OP_SQ_B: begin
                mul_a = MUL_A_W'(r_step_y);
                mul_b = MUL_B_W'(r_step_y);
            end
            OP_MUL_AB: begin
                mul_a = MUL_A_W'(r_a_sq);
                mul_b = MUL_B_W'(r_step_y);
            end
            OP_T1: begin
                mul_a = MUL_A_W'(r_step_x) + MUL_A_W'(1);
                mul_b = MUL_B_W'(r_b_sq);
            end
            OP_T2: begin
                mul_a = (MUL_A_W'(r_step_y) << 1) - MUL_A_W'(1);
                mul_b = MUL_B_W'(r_a_sq);
            end
            OP_SQX: begin
                mul_a = (MUL_A_W'(r_step_x) << 1) + MUL_A_W'(1);
                mul_b = (MUL_B_W'(r_step_x) << 1) + MUL_B_W'(1);
            end
            OP_BSQ: begin
                mul_a = MUL_A_W'(r_prod);
                mul_b = MUL_B_W'(r_b_sq);
            end
            OP_SQY: begin
                mul_a = MUL_A_W'(r_step_y) - MUL_A_W'(1);
                mul_b = MUL_B_W'(r_step_y) - MUL_B_W'(1);
            end
            OP_ASQ: begin
                mul_a = MUL_A_W'(r_prod);
                mul_b = MUL_B_W'(r_a_sq);
            end
            OP_AB: begin
                mul_a = MUL_A_W'(r_a_sq);
                mul_b = MUL_B_W'(r_b_sq);
            end
            OP_U1: begin
                mul_a = (MUL_A_W'(r_step_x) << 1) + MUL_A_W'(3);
                mul_b = MUL_B_W'(r_b_sq);
            end
            OP_U2: begin
                mul_a = (MUL_A_W'(r_step_y) << 1) - MUL_A_W'(2);
                mul_b = MUL_B_W'(r_a_sq);
            end
            OP_V1: begin
                mul_a = (MUL_A_W'(r_step_x) << 1) + MUL_A_W'(2);
                mul_b = MUL_B_W'(r_b_sq);
            end
            OP_V2: begin
                mul_a = MUL_A_W'(3) - (MUL_A_W'(r_step_y) << 1);
                mul_b = MUL_B_W'(r_a_sq);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * mul_b;
    assign dec_prod  = DEC_BITS'(r_prod);
    assign dec_prod4 = dec_prod << 2;
    assign r1_switch = $signed({r_prev, 1'b0}) >= $signed({r_prod[PROD_W-1], r_prod});
    assign out_free  = !r_out_valid || i_out_ready;

    assign cx = COORD_BITS'($signed(r_cen_x));
    assign cy = COORD_BITS'($signed(r_cen_y));
    assign xe = COORD_BITS'(r_step_x);
    assign ye = COORD_BITS'(r_step_y);

    always_comb begin
        case (i_cmd.pt)
            2'd0: begin
                n_point_x = cx + xe;
                n_point_y = cy + ye;
            end
            2'd1: begin
                n_point_x = cx + xe;
                n_point_y = cy - ye;
            end
            2'd2: begin
                n_point_x = cx - xe;
                n_point_y = cy - ye;
            end
            default: begin
                n_point_x = cx - xe;
                n_point_y = cy + ye;
            end
        endcase
    end

    always_comb begin
        n_step_x     = r_step_x;
        n_step_y     = r_step_y;
        n_region_two = r_region_two;
        n_dec        = r_dec;
        n_a_sq       = r_a_sq;
        n_b_sq       = r_b_sq;
        n_prod       = r_prod;
        n_prev       = r_prev;
        n_neg        = r_neg;
        n_out_valid  = r_out_valid && !i_out_ready;
        case (i_cmd.op)
            OP_LOAD: begin
                n_step_x     = '0;
                n_step_y     = i_axis_b;
                n_region_two = 1'b0;
                n_a_sq       = SQ_BITS'(mul_p);
            end
            OP_SQ_B: begin
                n_b_sq = SQ_BITS'(mul_p);
            end
            OP_MUL_AB: begin
                n_prod = mul_p;
            end
            OP_INIT_D: begin
                n_dec = (DEC_BITS'(r_b_sq) << 2) + DEC_BITS'(r_a_sq) - dec_prod4;
            end
            OP_T1: begin
                n_prod = mul_p;
            end
            OP_T2: begin
                n_prev = r_prod;
                n_prod = mul_p;
            end
            OP_TEST: begin
                n_region_two = r_region_two || r1_switch;
            end
            OP_SQX, OP_BSQ, OP_ASQ: begin
                n_prod = mul_p;
            end
            OP_SQY: begin
                n_dec  = dec_prod;
                n_prod = mul_p;
            end
            OP_AB: begin
                n_dec  = r_dec + dec_prod4;
                n_prod = mul_p;
            end
            OP_FIX: begin
                n_dec = r_dec - dec_prod4;
            end
            OP_U1, OP_V1: begin
                n_neg  = r_dec[DEC_BITS-1];
                n_prod = mul_p;
            end
            OP_U2: begin
                n_dec  = r_dec + dec_prod4;
                n_prod = mul_p;
            end
            OP_U3: begin
                if (!r_neg) begin
                    n_dec    = r_dec - dec_prod4;
                    n_step_y = r_step_y - AXIS_BITS'(1);
                end
                n_step_x = r_step_x + AXIS_BITS'(1);
            end
            OP_V2: begin
                if (r_neg) begin
                    n_dec    = r_dec + dec_prod4;
                    n_step_x = r_step_x + AXIS_BITS'(1);
                end
                n_prod = mul_p;
            end
            OP_V3: begin
                n_dec    = r_dec + dec_prod4;
                n_step_y = r_step_y - AXIS_BITS'(1);
            end
            OP_EMIT: begin
                n_out_valid = 1'b1;
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x     <= '0;
            r_step_y     <= '0;
            r_region_two <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_step_x     <= n_step_x;
            r_step_y     <= n_step_y;
            r_region_two <= n_region_two;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec  <= n_dec;
        r_a_sq <= n_a_sq;
        r_b_sq <= n_b_sq;
        r_prod <= n_prod;
        r_prev <= n_prev;
        r_neg  <= n_neg;
        if (i_cmd.op == OP_LOAD) begin
            r_cen_x <= i_center_x;
            r_cen_y <= i_center_y;
        end
        if (i_cmd.op == OP_EMIT) begin
            r_point_x <= n_point_x;
            r_point_y <= n_point_y;
            r_last    <= (i_cmd.pt == PT_LAST);
            r_done    <= (r_step_y == '0);
        end
    end

    assign o_sts.busy       = (r_step_y != '0);
    assign o_sts.region_two = r_region_two;
    assign o_sts.r1_switch  = r1_switch;
    assign o_sts.out_free   = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_point_x      = r_point_x;
    assign o_point_y      = r_point_y;
    assign o_last_of_step = r_last;
    assign o_ellipse_done = r_done;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=>
            r_out_valid && $stable(r_point_x) && $stable(r_point_y) && $stable(r_last))
        else $error("Output register changed while the receiver stalled.");

    a_region_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_region_two && i_cmd.op != OP_LOAD |=> r_region_two)
        else $error("Region two was left without a new start request.");

endmodule

// ===== hdl/mer_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences the datapath operations of a start or step request and the
// emission of the four symmetric points.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_req_type,
    input  mer_pkg::t_dp_sts i_sts,
    output logic             o_in_ready,
    output mer_pkg::t_dp_cmd o_cmd
);
    import mer_pkg::*;

    t_state               r_state, n_state;
    logic [PT_BITS-1:0]   r_pt, n_pt;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type == REQ_START) begin
                        n_state = ST_SQ_B;
                    end else if (i_sts.busy) begin
                        n_state = i_sts.region_two ? ST_V1 : ST_T1;
                    end
                end
            end
            ST_SQ_B:   n_state = ST_MUL_AB;
            ST_MUL_AB: n_state = ST_INIT_D;
            ST_INIT_D: n_state = ST_EMIT;
            ST_T1:     n_state = ST_T2;
            ST_T2:     n_state = ST_TEST;
            ST_TEST:   n_state = i_sts.r1_switch ? ST_SQX : ST_U1;
            ST_SQX:    n_state = ST_BSQ;
            ST_BSQ:    n_state = ST_SQY;
            ST_SQY:    n_state = ST_ASQ;
            ST_ASQ:    n_state = ST_AB;
            ST_AB:     n_state = ST_FIX;
            ST_FIX:    n_state = ST_V1;
            ST_U1:     n_state = ST_U2;
            ST_U2:     n_state = ST_U3;
            ST_U3:     n_state = ST_EMIT;
            ST_V1:     n_state = ST_V2;
            ST_V2:     n_state = ST_V3;
            ST_V3:     n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_sts.out_free && r_pt == PT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_pt = r_pt;
        if (r_state == ST_EMIT && i_sts.out_free) begin
            n_pt = (r_pt == PT_LAST) ? '0 : r_pt + PT_BITS'(1);
        end
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd.pt   = r_pt;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.op   = (i_in_valid && i_req_type == REQ_START) ? OP_LOAD : OP_NOP;
            end
            ST_SQ_B:   o_cmd.op = OP_SQ_B;
            ST_MUL_AB: o_cmd.op = OP_MUL_AB;
            ST_INIT_D: o_cmd.op = OP_INIT_D;
            ST_T1:     o_cmd.op = OP_T1;
            ST_T2:     o_cmd.op = OP_T2;
            ST_TEST:   o_cmd.op = OP_TEST;
            ST_SQX:    o_cmd.op = OP_SQX;
            ST_BSQ:    o_cmd.op = OP_BSQ;
            ST_SQY:    o_cmd.op = OP_SQY;
            ST_ASQ:    o_cmd.op = OP_ASQ;
            ST_AB:     o_cmd.op = OP_AB;
            ST_FIX:    o_cmd.op = OP_FIX;
            ST_U1:     o_cmd.op = OP_U1;
            ST_U2:     o_cmd.op = OP_U2;
            ST_U3:     o_cmd.op = OP_U3;
            ST_V1:     o_cmd.op = OP_V1;
            ST_V2:     o_cmd.op = OP_V2;
            ST_V3:     o_cmd.op = OP_V3;
            ST_EMIT:   o_cmd.op = i_sts.out_free ? OP_EMIT : OP_NOP;
            default:   o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pt    <= '0;
        end else begin
            r_state <= n_state;
            r_pt    <= n_pt;
        end
    end

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sts.out_free |-> o_cmd.op != OP_EMIT)
        else $error("A point was emitted into a full output register.");

    a_pt_outside_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_EMIT |-> r_pt == '0)
        else $error("Point counter is not at zero outside emission.");

    a_test_in_region_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_T1 |-> !i_sts.region_two && i_sts.busy)
        else $error("Region one test started outside region one.");

endmodule

// ===== hdl/midpoint_ellipse_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Draws an ellipse one midpoint iteration per step request, four points each.
// ----------------------------------------------------------------------------
// Requests arrive on the input channel (i_in_valid / o_in_ready). A start
// request loads the center and semi-axes and returns the four symmetric
// points at the ends of the b semi-axis. Each step request runs one iteration and
// returns four more points; a step while no ellipse is active returns none.
// Points leave on the output channel (o_out_valid / i_out_ready), the fourth
// one of a request flagged by o_last_of_step; o_ellipse_done marks the
// points after which no iteration remains.
// One request is in work at a time. The run of a request is set by the shared
// multiplier, used at most once per sequencer step, and by the output register,
// which takes one point per cycle while the receiver is ready.
// The fourth point waits in the output register while the next request is
// accepted. A stalled receiver holds the point and the sequencer waits.
// Reset clears the step position, the region flag and the output valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_req_type,
    input  logic signed [mer_pkg::CEN_BITS-1:0]   i_center_x,
    input  logic signed [mer_pkg::CEN_BITS-1:0]   i_center_y,
    input  logic        [mer_pkg::AXIS_BITS-1:0]  i_axis_a,
    input  logic        [mer_pkg::AXIS_BITS-1:0]  i_axis_b,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [mer_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [mer_pkg::COORD_BITS-1:0] o_point_y,
    output logic                                  o_last_of_step,
    output logic                                  o_ellipse_done
);
    import mer_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_sts      (dp_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    mer_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_axis_a       (i_axis_a),
        .i_axis_b       (i_axis_b),
        .i_out_ready    (i_out_ready),
        .o_sts          (dp_sts),
        .o_out_valid    (o_out_valid),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last_of_step (o_last_of_step),
        .o_ellipse_done (o_ellipse_done)
    );

endmodule

// ===== verif/midpoint_ellipse_rasterizer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer testbench
// Sends start and step requests to the rasterizer and checks every point it
// returns against an in-bench copy of the ellipse iteration. A short directed
// list covers the axis extremes, zero axes, steps with no ellipse active and
// restarts in the middle of an ellipse. Random ellipses follow, most of them
// small and run to completion, some cut short, mixed with stray requests.
// Both channels idle at random in the first two of three phases, and the receiver holds off
// once for a long stretch so that the request channel backs up.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_tb;
    import mer_pkg::*;

    localparam int RANDOM_POINT_REQS = 380;
    localparam int HOLD_CYCLES       = 300;
    localparam int DRAIN_CYCLES      = 64;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int REPORT_LIMIT      = 10;

    typedef struct packed {
        logic                 req_type;
        logic [CEN_BITS-1:0]  center_x;
        logic [CEN_BITS-1:0]  center_y;
        logic [AXIS_BITS-1:0] axis_a;
        logic [AXIS_BITS-1:0] axis_b;
    } t_raster_req;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  last_flag;
        logic                  done_flag;
    } t_pixel;

    typedef struct packed {
        logic                 busy;
        logic                 region_two;
        logic [CEN_BITS-1:0]  cen_x;
        logic [CEN_BITS-1:0]  cen_y;
        logic [AXIS_BITS-1:0] step_x;
        logic [AXIS_BITS-1:0] step_y;
        logic [DEC_BITS-1:0]  decision;
        logic [SQ_BITS-1:0]   a_sq;
        logic [SQ_BITS-1:0]   b_sq;
    } t_ellipse_state;

    logic i_clk;
    logic i_rst_n = 1'b0;

    t_raster_req offered   = '0;
    logic        in_valid  = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic signed [COORD_BITS-1:0] o_point_x;
    logic signed [COORD_BITS-1:0] o_point_y;
    logic        o_last_of_step;
    logic        o_ellipse_done;

    t_raster_req    req_backlog[$];
    t_pixel         expected_pixels[$];
    t_ellipse_state ellipse_now  = '0;
    t_ellipse_state ellipse_plan = '0;

    int total_reqs    = 0;
    int reqs_accepted = 0;
    int plan_emitting = 0;
    int pixel_errors  = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    int hold_at       = 0;
    bit hold_done     = 1'b0;
    int send_idle;
    int recv_idle;

    midpoint_ellipse_rasterizer u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (offered.req_type),
        .i_center_x     (offered.center_x),
        .i_center_y     (offered.center_y),
        .i_axis_a       (offered.axis_a),
        .i_axis_b       (offered.axis_b),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_last_of_step (o_last_of_step),
        .o_ellipse_done (o_ellipse_done)
    );

    // Applies one request to an ellipse state and returns whether it emits
    // points. The decision value is held at four times the midpoint value.
    function automatic bit ellipse_iterate(inout t_ellipse_state s, input t_raster_req r);
        logic [63:0] a2, b2, x, y, d, av, bv;
        bit          neg;
        if (r.req_type == REQ_START) begin
            av = 64'(r.axis_a);
            bv = 64'(r.axis_b);
            s.cen_x      = r.center_x;
            s.cen_y      = r.center_y;
            s.a_sq       = SQ_BITS'(av * av);
            s.b_sq       = SQ_BITS'(bv * bv);
            d            = 64'd4 * 64'(s.b_sq) + 64'(s.a_sq) - 64'd4 * 64'(s.a_sq) * bv;
            s.decision   = d[DEC_BITS-1:0];
            s.step_x     = '0;
            s.step_y     = r.axis_b;
            s.region_two = 1'b0;
            s.busy       = (r.axis_b != 0);
            return 1'b1;
        end
        if (!s.busy) begin
            return 1'b0;
        end
        a2 = 64'(s.a_sq);
        b2 = 64'(s.b_sq);
        x  = 64'(s.step_x);
        y  = 64'(s.step_y);
        d  = 64'(s.decision);
        if (!s.region_two && (64'd2 * b2 * (x + 64'd1) >= a2 * (64'd2 * y - 64'd1))) begin
            s.region_two = 1'b1;
            d = b2 * (64'd2 * x + 64'd1) * (64'd2 * x + 64'd1)
                + 64'd4 * a2 * (y - 64'd1) * (y - 64'd1) - 64'd4 * a2 * b2;
        end
        d   = 64'(d[DEC_BITS-1:0]);
        neg = d[DEC_BITS-1];
        if (!s.region_two) begin
            d = d + 64'd4 * b2 * (64'd2 * x + 64'd3);
            if (!neg) begin
                d = d - 64'd4 * a2 * (64'd2 * y - 64'd2);
                y = y - 64'd1;
            end
            x = x + 64'd1;
        end else begin
            if (neg) begin
                d = d + 64'd4 * b2 * (64'd2 * x + 64'd2);
                x = x + 64'd1;
            end
            d = d + 64'd4 * a2 * (64'd3 - 64'd2 * y);
            y = y - 64'd1;
        end
        s.decision = d[DEC_BITS-1:0];
        s.step_x   = x[AXIS_BITS-1:0];
        s.step_y   = y[AXIS_BITS-1:0];
        s.busy     = (s.step_y != 0);
        return 1'b1;
    endfunction

    function automatic t_pixel ellipse_pixel(input t_ellipse_state s, input int idx);
        logic [COORD_BITS-1:0] cx, cy, dx, dy;
        t_pixel                p;
        cx = {s.cen_x[CEN_BITS-1], s.cen_x};
        cy = {s.cen_y[CEN_BITS-1], s.cen_y};
        dx = COORD_BITS'(s.step_x);
        dy = COORD_BITS'(s.step_y);
        p.x         = (idx < 2) ? cx + dx : cx - dx;
        p.y         = (idx == 0 || idx == 3) ? cy + dy : cy - dy;
        p.last_flag = (idx == NUM_POINTS - 1);
        p.done_flag = (s.step_y == 0);
        return p;
    endfunction

    function automatic t_raster_req random_req(input logic kind);
        t_raster_req r;
        r.req_type = kind;
        r.center_x = CEN_BITS'($urandom);
        r.center_y = CEN_BITS'($urandom);
        r.axis_a   = AXIS_BITS'($urandom);
        r.axis_b   = AXIS_BITS'($urandom);
        return r;
    endfunction

    task automatic queue_req(input t_raster_req r);
        if (ellipse_iterate(ellipse_plan, r)) begin
            plan_emitting++;
        end
        req_backlog.push_back(r);
    endtask

    task automatic queue_ellipse(input logic [CEN_BITS-1:0] cx, input logic [CEN_BITS-1:0] cy,
                                 input logic [AXIS_BITS-1:0] a, input logic [AXIS_BITS-1:0] b,
                                 input int max_steps);
        t_raster_req r;
        int          n;
        r          = random_req(REQ_START);
        r.center_x = cx;
        r.center_y = cy;
        r.axis_a   = a;
        r.axis_b   = b;
        queue_req(r);
        n = 0;
        while (ellipse_plan.busy && n < max_steps) begin
            queue_req(random_req(REQ_STEP));
            n++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always_comb begin
        if (reqs_accepted < total_reqs / 3) begin
            send_idle = 21;
            recv_idle = 85;
        end else if (reqs_accepted < 2 * total_reqs / 3) begin
            send_idle = 85;
            recv_idle = 21;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    end

    // Request driver: predicts the points of each accepted request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                if (ellipse_iterate(ellipse_now, offered)) begin
                    for (int k = 0; k < NUM_POINTS; k++) begin
                        expected_pixels.push_back(ellipse_pixel(ellipse_now, k));
                    end
                end
                reqs_accepted <= reqs_accepted + 1;
            end
            if (!in_valid || o_in_ready) begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
                    offered  <= req_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // The long receiver hold-off, timed in its own process.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_accepted == hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Point monitor.
    always @(posedge i_clk) begin
        t_pixel got;
        t_pixel want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                got = {o_point_x, o_point_y, o_last_of_step, o_ellipse_done};
                if (expected_pixels.size() == 0) begin
                    pixel_errors++;
                    if (pixel_errors <= REPORT_LIMIT) begin
                        $display("unexpected point: x=%0d y=%0d last=%0b done=%0b",
                                 o_point_x, o_point_y, o_last_of_step, o_ellipse_done);
                    end
                end else begin
                    want = expected_pixels.pop_front();
                    if (got.x !== want.x || got.y !== want.y ||
                        got.last_flag !== want.last_flag || got.done_flag !== want.done_flag) begin
                        pixel_errors++;
                        if (pixel_errors <= REPORT_LIMIT) begin
                            $display("point mismatch: expected x=%0d y=%0d last=%0b done=%0b, %s",
                                     $signed(want.x), $signed(want.y), want.last_flag,
                                     want.done_flag, "got");
                            $display("                got      x=%0d y=%0d last=%0b done=%0b",
                                     o_point_x, o_point_y, o_last_of_step, o_ellipse_done);
                        end
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("midpoint_ellipse_rasterizer_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int          pick;
        int          cap;
        logic [AXIS_BITS-1:0] a;
        logic [AXIS_BITS-1:0] b;

        queue_req(random_req(REQ_STEP));
        queue_ellipse(12'h000, 12'h000, 11'd0, 11'd0, 0);
        queue_req(random_req(REQ_STEP));
        queue_ellipse(12'h800, 12'h7FF, 11'h7FF, 11'h7FF, 3);
        queue_ellipse(12'h7FF, 12'h800, 11'd1, 11'd1, 8);
        queue_req(random_req(REQ_STEP));
        queue_ellipse(12'hFFB, 12'h010, 11'd9, 11'd0, 8);
        queue_ellipse(12'h020, 12'hFF0, 11'd0, 11'd5, 8);
        queue_ellipse(12'h100, 12'h0C0, 11'd3, 11'd2, 10);
        queue_ellipse(12'h001, 12'hFFF, 11'h7FF, 11'd1, 2);

        plan_emitting = 0;
        while (plan_emitting < RANDOM_POINT_REQS) begin
            pick = $urandom_range(99);
            if (pick < 12) begin
                queue_req(random_req(logic'($urandom_range(1))));
            end else begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    a   = AXIS_BITS'($urandom_range(20));
                    b   = AXIS_BITS'($urandom_range(20));
                    cap = 1000;
                end else if (pick < 92) begin
                    a   = AXIS_BITS'($urandom_range(60));
                    b   = AXIS_BITS'($urandom_range(60));
                    cap = 40;
                end else begin
                    a   = AXIS_BITS'($urandom);
                    b   = AXIS_BITS'($urandom);
                    cap = 12;
                end
                if ($urandom_range(99) < 20) begin
                    cap = $urandom_range(6);
                end
                queue_ellipse(CEN_BITS'($urandom), CEN_BITS'($urandom), a, b, cap);
                if ($urandom_range(99) < 15) begin
                    queue_req(random_req(REQ_STEP));
                end
            end
        end
        total_reqs = req_backlog.size();
        hold_at    = total_reqs * 5 / 6;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_accepted < total_reqs) @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pixel_errors == 0) begin
            $display("midpoint_ellipse_rasterizer_tb: done, clean");
        end else begin
            $display("midpoint_ellipse_rasterizer_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== midpoint_ellipse_rasterizer.f =====
hdl/mer_pkg.sv
hdl/mer_datapath.sv
hdl/mer_ctrl.sv
hdl/midpoint_ellipse_rasterizer.sv
verif/midpoint_ellipse_rasterizer_tb.sv
